FILE: rtl/gcc_pkg.sv
package gcc_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int ROW_W        = 32;
  localparam int INDEX_W      = 5;
  localparam int CFG_W        = 6;
  localparam int CNT_W        = 6;
  localparam int LANE_COUNT   = 8;
  localparam logic [CFG_W-1:0] COUNT_RESET = 6'd32;

  typedef struct packed {
    logic [INDEX_W-1:0] row_index;
    logic [ROW_W-1:0]   row_bits;
    logic               last_row;
  } in_t;

  typedef struct packed {
    logic             connected;
    logic [CNT_W-1:0] reached_count;
  } out_t;

  // what every lane sees during a spread step
  typedef struct packed {
    logic [ROW_W-1:0] reach;
    logic [ROW_W-1:0] mask;
  } spread_t;

  function automatic logic [3:0] popcount8(input logic [7:0] b);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + 4'(b[i]);
    end
    return c;
  endfunction

endpackage

FILE: rtl/gcc_lane.sv
// One lane: ORs the masked rows of its group whose vertex is already reached.
module gcc_lane #(
  parameter int FIRST = 0,
  parameter int SIZE  = 4
) (
  input  logic                                 clk,
  input  gcc_pkg::spread_t                     spread,
  input  logic [SIZE-1:0][gcc_pkg::ROW_W-1:0] rows,
  input  logic [SIZE-1:0]                      row_valid,
  output logic [gcc_pkg::ROW_W-1:0]            partial
);

  logic [SIZE-1:0][gcc_pkg::ROW_W-1:0] term;
  logic [gcc_pkg::ROW_W-1:0]           acc;

  genvar k;
  generate
    for (k = 0; k < SIZE; k++) begin : g_term
      if (FIRST + k < gcc_pkg::ROW_W) begin : g_hit
        assign term[k] = (row_valid[k] && spread.reach[FIRST + k]) ?
                         (rows[k] & spread.mask) : '0;
      end else begin : g_none
        // vertices past the row width are never reached
        assign term[k] = '0;
      end
    end
  endgenerate

  always_comb begin
    acc = '0;
    for (int i = 0; i < SIZE; i++) begin
      acc = acc | term[i];
    end
  end

  always_ff @(posedge clk) begin
    partial <= acc;
  end

endmodule

FILE: rtl/graph_connectivity_check.sv
// Directed reachability check over an adjacency matrix.
// Input channel (in_valid/in_ready/in_data): one adjacency row per request,
// bit j of row_bits meaning an edge row_index -> j. Rows load at one per
// cycle while in LOAD. The last_row request is stored and starts the check.
// Config channel (cfg_valid/cfg_ready/cfg_data): vertex_count, always ready;
// write it only while the block is idle. Counts of 0 act as 1, counts above
// MAX_VERTICES act as MAX_VERTICES.
// The check runs reach-set iterations, each one lane step (SPREAD) plus one
// merge step (MERGE), stopping on the first iteration that adds nothing: at
// most n iterations for n vertices. FINISH then writes the verdict into the
// output register.
// Output channel (out_valid/out_ready/out_data): connected flag and reached
// count. The output register lets loading of the next graph proceed while a
// verdict waits; if a new verdict is ready before the old one is taken, the
// block holds in its final step until out_ready frees the register.
// Reset (rst, synchronous) clears the row valid bits, sets vertex_count to 32
// and drops out_valid. The row valid bits are also cleared after each verdict.
module graph_connectivity_check #(
  parameter int MAX_VERTICES = gcc_pkg::MAX_VERTICES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  gcc_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output gcc_pkg::out_t             out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [gcc_pkg::CFG_W-1:0] cfg_data
);

  localparam int NW     = $clog2(MAX_VERTICES + 1);
  localparam int LANES  = gcc_pkg::LANE_COUNT;
  localparam int GROUP  = (MAX_VERTICES + LANES - 1) / LANES;
  localparam int SLOTS  = LANES * GROUP;
  localparam int AW     = $clog2(SLOTS);
  localparam int CW     = (NW > gcc_pkg::CFG_W) ? NW : gcc_pkg::CFG_W;
  localparam int ROW_W  = gcc_pkg::ROW_W;

  typedef enum logic [1:0] {LOAD, SPREAD, MERGE, FINISH} state_t;

  state_t                         state;
  logic [gcc_pkg::CFG_W-1:0]      vertex_count;
  logic [NW-1:0]                  n_eff;
  logic [NW-1:0]                  n_next;
  logic [CW-1:0]                  vc_ext;
  logic [ROW_W-1:0]               reach;
  logic [ROW_W-1:0]               mask;
  logic [ROW_W-1:0]               merged;
  logic [SLOTS-1:0][ROW_W-1:0]    adj;
  logic [SLOTS-1:0]               row_valid;
  logic [LANES-1:0][ROW_W-1:0]    lane_or;
  gcc_pkg::spread_t               spread;
  gcc_pkg::out_t                  verdict;
  logic                           in_ok;
  logic                           in_range;
  logic [AW-1:0]                  idx_w;

  assign in_ready  = (state == LOAD);
  assign cfg_ready = 1'b1;
  assign in_ok     = in_valid && in_ready;
  assign in_range  = int'(in_data.row_index) < MAX_VERTICES;
  assign idx_w     = AW'(in_data.row_index);

  // clamp the count to 1..MAX_VERTICES
  always_comb begin
    vc_ext = CW'(vertex_count);
    if (vc_ext == '0) begin
      n_next = NW'(1);
    end else if (vc_ext > CW'(MAX_VERTICES)) begin
      n_next = NW'(MAX_VERTICES);
    end else begin
      n_next = NW'(vc_ext);
    end
  end

  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      mask[j] = int'(n_eff) > j;
    end
  end

  assign spread.reach = reach;
  assign spread.mask  = mask;

  genvar l;
  generate
    for (l = 0; l < LANES; l++) begin : g_lane
      gcc_lane #(
        .FIRST(l * GROUP),
        .SIZE (GROUP)
      ) u_lane (
        .clk      (clk),
        .spread   (spread),
        .rows     (adj[l * GROUP +: GROUP]),
        .row_valid(row_valid[l * GROUP +: GROUP]),
        .partial  (lane_or[l])
      );
    end
  endgenerate

  always_comb begin
    merged = reach;
    for (int i = 0; i < LANES; i++) begin
      merged = merged | lane_or[i];
    end
  end

  always_comb begin
    verdict.connected     = (int'(n_eff) <= ROW_W) && (reach == mask);
    verdict.reached_count = gcc_pkg::CNT_W'(gcc_pkg::popcount8(reach[7:0]))
                          + gcc_pkg::CNT_W'(gcc_pkg::popcount8(reach[15:8]))
                          + gcc_pkg::CNT_W'(gcc_pkg::popcount8(reach[23:16]))
                          + gcc_pkg::CNT_W'(gcc_pkg::popcount8(reach[31:24]));
  end

  // row data carries no reset; row_valid gates it
  always_ff @(posedge clk) begin
    if (in_ok && in_range) begin
      adj[idx_w] <= in_data.row_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= LOAD;
      vertex_count <= gcc_pkg::COUNT_RESET;
      row_valid    <= '0;
      out_valid    <= 1'b0;
      n_eff        <= NW'(1);
      reach        <= ROW_W'(1);
    end else begin
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      // FINISH reloads the register itself when it is freed
      if (out_valid && out_ready && state != FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        LOAD: begin
          if (in_ok) begin
            if (in_range) begin
              row_valid[idx_w] <= 1'b1;
            end
            if (in_data.last_row) begin
              n_eff <= n_next;
              reach <= ROW_W'(1);
              state <= SPREAD;
            end
          end
        end
        SPREAD: begin
          state <= MERGE;
        end
        MERGE: begin
          reach <= merged;
          state <= (merged == reach) ? FINISH : SPREAD;
        end
        FINISH: begin
          if (!out_valid || out_ready) begin
            out_data  <= verdict;
            out_valid <= 1'b1;
            row_valid <= '0;
            state     <= LOAD;
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

endmodule
